FILE: rtl/ibwa_pkg.sv
// Shared constants and types for the box weighted average block.
`default_nettype none
package ibwa_pkg;

    // Fraction bits of the table values and the result
    localparam int FRAC_BITS = 16;
    // Corner value, box sum, result and threshold widths
    localparam int IN_W      = 48;
    localparam int SUM_W     = IN_W + 2;
    localparam int OUT_W     = 32;
    localparam int THR_W     = 16;
    // Integer bits of the result; dividend bits above them seed the remainder
    localparam int SHIFT     = OUT_W - FRAC_BITS;
    // Front stages, one divider cell per quotient bit, output register
    localparam int LATENCY   = 4 + OUT_W + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam logic [OUT_W-1:0] SENTINEL  = {{SHIFT{1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [OUT_W-1:0] LIM_POS   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] LIM_NEG   = {1'b1, {(OUT_W-1){1'b0}}};

    // Word handed from one divider cell to the next
    typedef struct packed {
        logic             vld;     // item present
        logic             mvalid;  // weight sum above threshold
        logic             neg;     // quotient is negative
        logic             ovf;     // quotient magnitude reaches 2^OUT_W
        logic [SUM_W-1:0] rem;     // partial remainder
        logic [SUM_W-1:0] den;     // divisor magnitude
        logic [OUT_W-1:0] word;    // dividend bits left on top, quotient bits below
    } t_div;

endpackage
`default_nettype wire

FILE: rtl/ibwa_front.sv
// Box sums, magnitudes, threshold and range checks ahead of the divider chain.
`default_nettype none
module ibwa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [ibwa_pkg::THR_W-1:0]          i_thr,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_dbr,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_dtr,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_dbl,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_dtl,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_wbr,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_wtr,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_wbl,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_wtl,
    output ibwa_pkg::t_div                      o_div
);
    import ibwa_pkg::*;

    // Stage 1: pairwise differences
    logic              r_v1;
    logic [IN_W:0]     r_da, r_db, r_wa, r_wb;
    logic [IN_W:0]     n_da, n_db, n_wa, n_wb;
    // Stage 2: box sums
    logic              r_v2;
    logic [SUM_W-1:0]  r_dsum, r_wsum;
    logic [SUM_W-1:0]  n_dsum, n_wsum;
    // Stage 3: magnitudes and sign
    logic              r_v3;
    logic              r_neg;
    logic [SUM_W-1:0]  r_n, r_d;
    logic [SUM_W-1:0]  n_n, n_d;
    // Stage 4: divider seed
    t_div              r_div;
    t_div              n_div;

    // Form bottom-right minus top-right and top-left minus bottom-left
    always_comb begin
        n_da = {i_dbr[IN_W-1], i_dbr} - {i_dtr[IN_W-1], i_dtr};
        n_db = {i_dtl[IN_W-1], i_dtl} - {i_dbl[IN_W-1], i_dbl};
        n_wa = {i_wbr[IN_W-1], i_wbr} - {i_wtr[IN_W-1], i_wtr};
        n_wb = {i_wtl[IN_W-1], i_wtl} - {i_wbl[IN_W-1], i_wbl};
    end

    // Add the two differences into the box sums
    always_comb begin
        n_dsum = {r_da[IN_W], r_da} + {r_db[IN_W], r_db};
        n_wsum = {r_wa[IN_W], r_wa} + {r_wb[IN_W], r_wb};
    end

    // Take magnitudes
    always_comb begin
        n_n = r_dsum[SUM_W-1] ? (SUM_W'(0) - r_dsum) : r_dsum;
        n_d = r_wsum[SUM_W-1] ? (SUM_W'(0) - r_wsum) : r_wsum;
    end

    // Check threshold and range, seed remainder with the top dividend bits
    always_comb begin
        n_div        = '0;
        n_div.vld    = r_v3;
        n_div.mvalid = (r_d > SUM_W'(i_thr));
        n_div.neg    = r_neg;
        n_div.ovf    = ((r_n >> SHIFT) >= r_d);
        n_div.rem    = r_n >> SHIFT;
        n_div.den    = r_d;
        n_div.word   = {r_n[SHIFT-1:0], {FRAC_BITS{1'b0}}};
    end

    // Advance stage valids and the divider seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_div <= '0;
        end else begin
            r_v1  <= i_vld;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_div <= n_div;
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        r_da          <= n_da;
        r_db          <= n_db;
        r_wa          <= n_wa;
        r_wb          <= n_wb;
        r_dsum        <= n_dsum;
        r_wsum        <= n_wsum;
        r_n           <= n_n;
        r_d           <= n_d;
        r_neg         <= r_dsum[SUM_W-1] ^ r_wsum[SUM_W-1];
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

FILE: rtl/ibwa_div_cell.sv
// One restoring division cell: shifts in a dividend bit, yields one quotient bit.
`default_nettype none
module ibwa_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ibwa_pkg::t_div  i_div,
    output ibwa_pkg::t_div  o_div
);
    import ibwa_pkg::*;

    t_div           r_div;
    t_div           n_div;
    logic [SUM_W:0] rem_sh;
    logic           take;

    // Shift the next dividend bit into the remainder and try a subtract
    always_comb begin
        rem_sh      = {i_div.rem, i_div.word[OUT_W-1]};
        take        = (rem_sh >= {1'b0, i_div.den});
        n_div       = i_div;
        n_div.rem   = take ? SUM_W'(rem_sh - {1'b0, i_div.den}) : rem_sh[SUM_W-1:0];
        n_div.word  = {i_div.word[OUT_W-2:0], take};
    end

    // Hand the word to the next cell, clear it under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
        end else begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

FILE: rtl/ibwa_out.sv
// Saturation, sign and sentinel selection, registered onto the result ports.
`default_nettype none
module ibwa_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ibwa_pkg::t_div                      i_div,
    output logic                                o_done,
    output logic signed [ibwa_pkg::OUT_W-1:0]   o_mean_depth,
    output logic                                o_mean_valid
);
    import ibwa_pkg::*;

    logic             r_done;
    logic [OUT_W-1:0] r_mean;
    logic             r_mvalid;
    logic [OUT_W-1:0] limit;
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] n_mean;

    // Clamp the quotient, apply sign, or drop to the sentinel
    always_comb begin
        limit  = i_div.neg ? LIM_NEG : LIM_POS;
        mag    = (i_div.ovf || (i_div.word > limit)) ? limit : i_div.word;
        n_mean = i_div.mvalid ? (i_div.neg ? (OUT_W'(0) - mag) : mag) : SENTINEL;
    end

    // Strobe one cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_div.vld;
        end
    end

    // Capture result word
    always_ff @(posedge i_clk) begin
        r_mean   <= n_mean;
        r_mvalid <= i_div.mvalid;
    end

    assign o_done       = r_done;
    assign o_mean_depth = r_mean;
    assign o_mean_valid = r_mvalid;

endmodule
`default_nettype wire

FILE: rtl/integral_box_weighted_average.sv
// Top level: weighted mean depth of a box from two summed-area table corner sets.
// Path: an accepted item runs through the front stages, the divider cells and the output
//   register, whose strobe marks the result (4 front, 32 divider cells, 1 output).
// Throughput: one item per cycle while busy is low; the chain of divider cells sets the latency.
// Reset: synchronous, active low; clears the pipeline valids, sets the threshold to 1
//   and holds busy high until the clock after reset is released; the receiver cannot stall.
`default_nettype none
module integral_box_weighted_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_depth_bottom_right,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_depth_top_right,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_depth_bottom_left,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_depth_top_left,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_weight_bottom_right,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_weight_top_right,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_weight_bottom_left,
    input  logic signed [ibwa_pkg::IN_W-1:0]    i_weight_top_left,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ibwa_pkg::THR_W-1:0]          i_cfg_data,
    output logic                                o_done,
    output logic signed [ibwa_pkg::OUT_W-1:0]   o_mean_depth,
    output logic                                o_mean_valid
);
    import ibwa_pkg::*;

    logic             r_busy;
    logic [THR_W-1:0] r_thr;
    logic             accept;
    t_div             chain [0:OUT_W];

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // Hold busy through reset, release it on the clock after reset ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Write the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    ibwa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_thr   (r_thr),
        .i_dbr   (i_depth_bottom_right),
        .i_dtr   (i_depth_top_right),
        .i_dbl   (i_depth_bottom_left),
        .i_dtl   (i_depth_top_left),
        .i_wbr   (i_weight_bottom_right),
        .i_wtr   (i_weight_top_right),
        .i_wbl   (i_weight_bottom_left),
        .i_wtl   (i_weight_top_left),
        .o_div   (chain[0])
    );

    // One cell per quotient bit
    for (genvar k = 0; k < OUT_W; k++) begin : g_cell
        ibwa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (chain[k]),
            .o_div   (chain[k+1])
        );
    end

    ibwa_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_div        (chain[OUT_W]),
        .o_done       (o_done),
        .o_mean_depth (o_mean_depth),
        .o_mean_valid (o_mean_valid)
    );

endmodule
`default_nettype wire

FILE: rtl/ibwa_checker.sv
// Port-level checker for the box weighted average block, with its bind.
`default_nettype none
module ibwa_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_done,
    input  logic signed [ibwa_pkg::OUT_W-1:0]   o_mean_depth,
    input  logic                                o_mean_valid
);
    import ibwa_pkg::*;

    // Block comes out of reset busy
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // Every strobe traces back to an accepted word a fixed latency earlier
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without accepted word");

    // An invalid mean carries the minus-one sentinel
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_mean_valid) |-> (o_mean_depth == SENTINEL))
        else $error("invalid mean without sentinel");

    // No result strobe in the first cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("strobe right after reset");

endmodule

bind integral_box_weighted_average ibwa_checker u_ibwa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_mean_depth (o_mean_depth),
    .o_mean_valid (o_mean_valid)
);
`default_nettype wire

FILE: tb/integral_box_weighted_average_tb.sv
// Self-checking testbench for the box weighted average block: corner words in, mean words out.
`default_nettype none
module integral_box_weighted_average_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ibwa_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_PER_PHASE = 285;
    localparam logic signed [IN_W-1:0] CORNER_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] CORNER_MIN = {1'b1, {(IN_W-1){1'b0}}};

    // Corner values of one box from both tables
    typedef struct packed {
        logic signed [IN_W-1:0] d_br;
        logic signed [IN_W-1:0] d_tr;
        logic signed [IN_W-1:0] d_bl;
        logic signed [IN_W-1:0] d_tl;
        logic signed [IN_W-1:0] w_br;
        logic signed [IN_W-1:0] w_tr;
        logic signed [IN_W-1:0] w_bl;
        logic signed [IN_W-1:0] w_tl;
    } t_box;

    // Mean word as the block returns it
    typedef struct packed {
        logic [OUT_W-1:0] mean;
        logic             vld;
    } t_mean;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    t_box                      box_drv = '0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [THR_W-1:0]          i_cfg_data = '0;
    logic                      o_done;
    logic signed [OUT_W-1:0]   o_mean_depth;
    logic                      o_mean_valid;

    t_box             box_queue[$];
    t_mean            pending_means[$];
    logic [THR_W-1:0] weight_thr = THR_RESET;
    logic             box_taken = 1'b0;
    int               burst_left = 1;
    int               gap_left = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    integral_box_weighted_average u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_depth_bottom_right  (box_drv.d_br),
        .i_depth_top_right     (box_drv.d_tr),
        .i_depth_bottom_left   (box_drv.d_bl),
        .i_depth_top_left      (box_drv.d_tl),
        .i_weight_bottom_right (box_drv.w_br),
        .i_weight_top_right    (box_drv.w_tr),
        .i_weight_bottom_left  (box_drv.w_bl),
        .i_weight_top_left     (box_drv.w_tl),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_mean_depth          (o_mean_depth),
        .o_mean_valid          (o_mean_valid)
    );

    // Clock: 1 ns high, 1 ns low
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Random signed value spanning the given number of bits
    function automatic longint rand_s(int bits);
        longint v;
        v = {$urandom, $urandom};
        return v >>> (64 - bits);
    endfunction

    // Build corners around the wanted box sums, with random other corners
    function automatic t_box make_box(longint dsum, longint wsum);
        t_box b;
        b.d_tr = IN_W'(rand_s(40));
        b.d_bl = IN_W'(rand_s(40));
        b.d_tl = IN_W'(rand_s(40));
        b.d_br = IN_W'(dsum + b.d_tr + b.d_bl - b.d_tl);
        b.w_tr = IN_W'(rand_s(40));
        b.w_bl = IN_W'(rand_s(40));
        b.w_tl = IN_W'(rand_s(40));
        b.w_br = IN_W'(wsum + b.w_tr + b.w_bl - b.w_tl);
        return b;
    endfunction

    // Drive the depth or weight corners to the largest or smallest box sum
    function automatic t_box widest(t_box b, logic on_depth, logic up);
        logic signed [IN_W-1:0] hi, lo;
        hi = up ? CORNER_MAX : CORNER_MIN;
        lo = up ? CORNER_MIN : CORNER_MAX;
        if (on_depth) begin
            b.d_br = hi; b.d_tr = lo; b.d_bl = lo; b.d_tl = hi;
        end else begin
            b.w_br = hi; b.w_tr = lo; b.w_bl = lo; b.w_tl = hi;
        end
        return b;
    endfunction

    // Random box: mostly chosen box sums near the interesting edges, some raw noise
    function automatic t_box random_box(logic [THR_W-1:0] thr);
        t_box   b;
        longint dsum, wsum;
        if ($urandom_range(0, 9) < 2) begin
            for (int i = 0; i < 12; i++)
                b = {b[$bits(t_box)-33:0], $urandom};
            return b;
        end
        case ($urandom_range(0, 7))
            0: wsum = 0;
            1: wsum = longint'(thr);
            2: wsum = longint'(thr) + 1;
            3: wsum = longint'($urandom_range(0, 32'(thr) + 3));
            4: wsum = rand_s(18);
            5: wsum = rand_s(33);
            default: wsum = rand_s(47);
        endcase
        if ($urandom_range(0, 1) == 1)
            wsum = -wsum;
        case ($urandom_range(0, 5))
            0: dsum = 0;
            1: dsum = rand_s(21);
            2: dsum = rand_s(41);
            3: dsum = rand_s(47);
            4: dsum = (wsum < (64'sd1 <<< 30) && wsum > -(64'sd1 <<< 30)) ?
                      wsum * rand_s(16) : rand_s(47);
            default: dsum = (wsum < (64'sd1 <<< 30) && wsum > -(64'sd1 <<< 30)) ?
                      wsum * ($urandom_range(0, 1) ? 32768 : -32768) + rand_s(4) :
                      rand_s(47);
        endcase
        return make_box(dsum, wsum);
    endfunction

    // Mean depth of one box: saturated truncated quotient of the box sums, or the sentinel
    function automatic t_mean box_mean(t_box b, logic [THR_W-1:0] thr);
        longint     dsum, wsum;
        logic [79:0] num, den, quo, lim;
        logic       neg;
        t_mean      m;
        dsum = longint'(b.d_br) - longint'(b.d_tr) - longint'(b.d_bl) + longint'(b.d_tl);
        wsum = longint'(b.w_br) - longint'(b.w_tr) - longint'(b.w_bl) + longint'(b.w_tl);
        den = 80'((wsum < 0) ? -wsum : wsum);
        if (den <= 80'(thr)) begin
            m.mean = SENTINEL;
            m.vld = 1'b0;
        end else begin
            num = 80'((dsum < 0) ? -dsum : dsum);
            num = num << FRAC_BITS;
            neg = (dsum < 0) != (wsum < 0);
            lim = 80'(neg ? LIM_NEG : LIM_POS);
            quo = num / den;
            if (quo > lim)
                quo = lim;
            m.mean = neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
            m.vld = 1'b1;
        end
        return m;
    endfunction

    // Driver: hold a word until taken, send bursts with random gaps between them
    always @(negedge i_clk) begin : drive_boxes
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !box_taken) begin
            // hold: block is busy
        end else if (gap_left != 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (box_queue.size() != 0) begin
            box_drv <= box_queue.pop_front();
            start <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
                             $urandom_range(1, 20);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predict on each taken word, check each mean word against the oldest
    always @(posedge i_clk) begin : check_means
        t_mean want, got;
        if (!i_rst_n) begin
            box_taken <= 1'b0;
            weight_thr <= THR_RESET;
        end else begin
            box_taken <= start && !busy;
            if (start && !busy)
                pending_means.push_back(box_mean(box_drv, weight_thr));
            if (i_cfg_valid && o_cfg_ready)
                weight_thr <= i_cfg_data;
            if (o_done) begin
                got = {o_mean_depth, o_mean_valid};
                if (pending_means.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected mean word: depth %0d valid %0b",
                                 o_mean_depth, o_mean_valid);
                    mismatches++;
                end else begin
                    want = pending_means.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"mean mismatch: want depth %0d valid %0b,",
                                      " got depth %0d valid %0b"},
                                     $signed(want.mean), want.vld, o_mean_depth,
                                     o_mean_valid);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Wait until every word is sent and every mean word is back, then let the pipe settle
    task automatic drain_boxes();
        while (box_queue.size() != 0 || start || pending_means.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Write the threshold register over its own handshake
    task automatic write_threshold(logic [THR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_box             b;
        logic [THR_W-1:0] thr_plan[6];
        longint           dir_d[13];
        longint           dir_w[13];

        // Box sums at the edges: threshold equality, sign mixes, saturation, truncation
        dir_d = '{0, 5, 3, 3, 65536, 65536, 2147483647, -1, 1, 2, 0, -(64'sd1 <<< 20),
                  (64'sd1 <<< 46)};
        dir_w = '{1, -1, 2, -2, -2, 2, 65536, 3, 3, -3, -7, 2, (64'sd1 <<< 46) - 1};

        thr_plan[0] = '0;
        thr_plan[1] = '1;
        thr_plan[2] = THR_W'($urandom_range(0, 65535));
        thr_plan[3] = THR_W'($urandom_range(2, 300));
        thr_plan[4] = THR_W'($urandom_range(0, 65535));
        thr_plan[5] = THR_W'(1);

        // Hold reset, then release it on a falling clock edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset threshold
        box_queue.push_back('0);
        box_queue.push_back({8{CORNER_MAX}});
        box_queue.push_back({8{CORNER_MIN}});
        box_queue.push_back(widest(make_box(0, 2), 1'b1, 1'b1));
        box_queue.push_back(widest(make_box(0, 2), 1'b1, 1'b0));
        b = widest(make_box(0, 0), 1'b1, 1'b1);
        box_queue.push_back(widest(b, 1'b0, 1'b1));
        box_queue.push_back(widest(b, 1'b0, 1'b0));
        for (int i = 0; i < 13; i++)
            box_queue.push_back(make_box(dir_d[i], dir_w[i]));
        drain_boxes();

        // Random words under a series of thresholds, extremes included
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_plan[p]);
            repeat (RAND_PER_PHASE)
                box_queue.push_back(random_box(thr_plan[p]));
            drain_boxes();
        end

        if (mismatches == 0 && pending_means.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/ibwa_pkg.sv
rtl/ibwa_front.sv
rtl/ibwa_div_cell.sv
rtl/ibwa_out.sv
rtl/integral_box_weighted_average.sv
rtl/ibwa_checker.sv
tb/integral_box_weighted_average_tb.sv
